>>> sv/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_WIDTH  = GLYPH_HEIGHT / 2;

  localparam int XY_W     = 13;
  localparam int ROWS_W   = 9;
  localparam int TAB_W    = 9;
  localparam int COLOR_W  = 24;
  localparam int CHAR_W   = 8;
  localparam int CFG_W    = 13;
  localparam int XY_MAX   = (1 << XY_W) - 1;
  localparam int ROWS_MAX = (1 << ROWS_W) - 1;

  typedef enum logic [1:0] {
    KIND_DRAW   = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [XY_W-1:0]  screen_width;
    logic [XY_W-1:0]  screen_height;
    logic [TAB_W-1:0] tab_step;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] color;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic [XY_W-1:0]     pos_x;
    logic [XY_W-1:0]     pos_y;
    logic [CHAR_W-1:0]   glyph;
    logic [COLOR_W-1:0]  draw_color;
    logic [ROWS_W-1:0]   scroll_rows;
    logic                last;
  } result_t;

  // Results of one item: how many (0 to 2), then in output order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> sv/text_console_cursor_engine_core.sv
// Top level of the text console cursor engine: ports, configuration registers and stage wiring.
`timescale 1ns / 1ps

// The engine takes one character or clear command per transfer on the slave side and
// emits draw-cell, scroll and clear commands on the master side. An accepted item is
// registered in the input stage, then its cursor update and results are worked out
// combinationally and loaded into the result register, whose head is offered on the
// master side. An item waits in the input stage while earlier results still fill the
// result register. Tab, newline without scroll and a backspace in the top-left
// corner produce no result and retire even while the result register is full.
// Sustained rate is one item per cycle while the master side takes one transfer per
// cycle. The result register delivers one transfer per cycle, so an item that scrolls
// and then draws holds it for both transfers, and the next item that has results waits
// in the input stage until the scroll has gone out. Configuration is a plain write port
// (0 screen_width, 1 screen_height, 2 tab_step) and must only be written while the
// engine is idle. Glyph cells are GLYPH_HEIGHT pixels high and half that wide; the
// row count is screen_height divided by the cell height.
module text_console_cursor_engine_core (
  input  logic        clk,
  input  logic        rst,
  // Slave side. tdata: char_code [7:0], color [31:8]. tuser: cmd.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  // Master side. tdata: pos_x [12:0], pos_y [25:13], glyph [33:26],
  // draw_color [57:34], scroll_rows [66:58], zero [71:67]. tuser: kind.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TAB_STEP      = 2'd2;

  tcce_pkg::cfg_t    cfg;
  tcce_pkg::item_t   in_item;
  tcce_pkg::item_t   item;
  tcce_pkg::push_t   push;
  tcce_pkg::result_t result;
  logic              in_full;
  logic              room;
  logic              commit;

  // Configuration registers; writes to an index past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 13'd1024;
      cfg.screen_height <= 13'd768;
      cfg.tab_step      <= 9'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        REG_TAB_STEP:      cfg.tab_step      <= cfg_data[tcce_pkg::TAB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.cmd       = s_tuser;
  assign in_item.char_code = s_tdata[7:0];
  assign in_item.color     = s_tdata[31:8];

  // An item retires when its results fit in the result register, or it has none.
  assign commit = in_full && ((push.num == 2'd0) || room);

  tcce_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .retire   (commit),
    .full     (in_full),
    .item     (item)
  );

  tcce_cursor u_cursor (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .commit (commit),
    .push   (push)
  );

  tcce_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (commit && (push.num != 2'd0)),
    .push       (push),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tuser = result.kind;
  assign m_tlast = result.last;
  assign m_tdata = {5'b0, result.scroll_rows, result.draw_color, result.glyph,
                    result.pos_y, result.pos_x};

endmodule

>>> sv/tcce_in_reg.sv
// Input register stage: holds one accepted item until the cursor logic retires it.
`timescale 1ns / 1ps

module tcce_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tcce_pkg::item_t in_item,
  input  logic            retire,
  output logic            full,
  output tcce_pkg::item_t item
);

  // A slot that retires this cycle can take the next item at the same edge.
  assign in_ready = !full || retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (retire) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> sv/tcce_cursor.sv
// Cursor state and the per-character update that yields draw, scroll and clear results.
`timescale 1ns / 1ps

module tcce_cursor (
  input  logic            clk,
  input  logic            rst,
  input  tcce_pkg::cfg_t  cfg,
  input  tcce_pkg::item_t item,
  input  logic            commit,
  output tcce_pkg::push_t push
);

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam int XW = tcce_pkg::XY_W;
  localparam int RW = tcce_pkg::ROWS_W;

  logic [XW-1:0] cursor_x, cursor_x_next;
  logic [XW-1:0] cursor_y, cursor_y_next;
  logic [RW-1:0] rows_in_use, rows_in_use_next;

  logic [RW-1:0] total;
  logic [XW:0]   y_down;
  logic [XW-1:0] y_down_sat;
  logic [XW:0]   x_tab;
  logic [RW-1:0] rows_inc;
  logic [RW-1:0] excess;
  logic [XW-1:0] up_nl;
  logic [XW-1:0] col0;
  logic [XW-1:0] row0;
  logic [XW:0]   bottom;
  logic [XW:0]   over;
  logic [RW:0]   needed;
  logic [XW:0]   up_ch;
  logic [XW-1:0] row_fin;
  logic [XW:0]   x_adv;

  tcce_pkg::result_t r0, r1;

  // Text rows that fit on the screen.
  assign total = RW'(cfg.screen_height / tcce_pkg::GLYPH_HEIGHT);

  // One row down from the current cursor, saturating at the coordinate limit.
  assign y_down     = {1'b0, cursor_y} + (XW+1)'(tcce_pkg::GLYPH_HEIGHT);
  assign y_down_sat = (y_down > (XW+1)'(tcce_pkg::XY_MAX)) ? XW'(tcce_pkg::XY_MAX)
                                                           : y_down[XW-1:0];

  assign x_tab = {1'b0, cursor_x} + (XW+1)'(cfg.tab_step);

  // Newline row bookkeeping.
  assign rows_inc = (rows_in_use != RW'(tcce_pkg::ROWS_MAX)) ? rows_in_use + 1'b1
                                                             : rows_in_use;
  assign excess   = rows_inc - total;
  assign up_nl    = XW'(excess * tcce_pkg::GLYPH_HEIGHT);

  // Printable character: wrap first, then see whether the cell leaves the screen.
  assign col0   = (cursor_x >= cfg.screen_width) ? '0 : cursor_x;
  assign row0   = (cursor_x >= cfg.screen_width) ? y_down_sat : cursor_y;
  assign bottom = {1'b0, row0} + (XW+1)'(tcce_pkg::GLYPH_HEIGHT);
  assign over   = bottom - {1'b0, cfg.screen_height};
  assign needed = (RW+1)'(({1'b0, over} + (XW+2)'(tcce_pkg::GLYPH_HEIGHT - 1))
                          / tcce_pkg::GLYPH_HEIGHT);
  assign up_ch  = (XW+1)'(needed * tcce_pkg::GLYPH_HEIGHT);
  assign row_fin = ({1'b0, row0} > up_ch) ? XW'({1'b0, row0} - up_ch) : '0;
  assign x_adv  = {1'b0, col0} + (XW+1)'(tcce_pkg::GLYPH_WIDTH);

  always_comb begin
    cursor_x_next    = cursor_x;
    cursor_y_next    = cursor_y;
    rows_in_use_next = rows_in_use;
    r0               = '0;
    r1               = '0;
    push.num         = 2'd0;

    if (item.cmd) begin
      cursor_x_next    = '0;
      cursor_y_next    = '0;
      rows_in_use_next = '0;
      r0.kind          = tcce_pkg::KIND_CLEAR;
      r0.last          = 1'b1;
      push.num         = 2'd1;
    end else begin
      case (item.char_code)
        CH_NEWLINE: begin
          cursor_x_next    = '0;
          cursor_y_next    = y_down_sat;
          rows_in_use_next = rows_inc;
          if (rows_inc > total) begin
            rows_in_use_next = total;
            cursor_y_next    = (y_down_sat > up_nl) ? y_down_sat - up_nl : '0;
            r0.kind          = tcce_pkg::KIND_SCROLL;
            r0.scroll_rows   = (excess < total) ? excess : total;
            r0.last          = 1'b1;
            push.num         = 2'd1;
          end
        end
        CH_TAB: begin
          cursor_x_next = (x_tab > (XW+1)'(tcce_pkg::XY_MAX)) ? XW'(tcce_pkg::XY_MAX)
                                                              : x_tab[XW-1:0];
        end
        CH_BACKSPACE: begin
          if (cursor_x != '0) begin
            cursor_x_next = (cursor_x > XW'(tcce_pkg::GLYPH_WIDTH))
                            ? cursor_x - XW'(tcce_pkg::GLYPH_WIDTH) : '0;
            r0.pos_x      = cursor_x_next;
            r0.pos_y      = cursor_y;
            r0.glyph      = CH_SPACE;
            r0.draw_color = item.color;
            r0.last       = 1'b1;
            push.num      = 2'd1;
          end else if (cursor_y >= XW'(tcce_pkg::GLYPH_HEIGHT)) begin
            // Column 0: step back to the last cell of the row above.
            cursor_x_next = (cfg.screen_width > XW'(tcce_pkg::GLYPH_WIDTH))
                            ? cfg.screen_width - XW'(tcce_pkg::GLYPH_WIDTH) : '0;
            cursor_y_next = cursor_y - XW'(tcce_pkg::GLYPH_HEIGHT);
            r0.pos_x      = cursor_x_next;
            r0.pos_y      = cursor_y_next;
            r0.glyph      = CH_SPACE;
            r0.draw_color = item.color;
            r0.last       = 1'b1;
            push.num      = 2'd1;
          end
        end
        default: begin
          cursor_x_next = (x_adv > (XW+1)'(tcce_pkg::XY_MAX)) ? XW'(tcce_pkg::XY_MAX)
                                                              : x_adv[XW-1:0];
          if (total == '0) begin
            // Screen lower than one cell: draw at the top and let downstream clip.
            cursor_y_next = '0;
            r0.pos_x      = col0;
            r0.pos_y      = '0;
            r0.glyph      = item.char_code;
            r0.draw_color = item.color;
            r0.last       = 1'b1;
            push.num      = 2'd1;
          end else if (bottom > {1'b0, cfg.screen_height}) begin
            cursor_y_next    = row_fin;
            rows_in_use_next = ({1'b0, rows_in_use} > needed)
                               ? RW'({1'b0, rows_in_use} - needed) : '0;
            r0.kind          = tcce_pkg::KIND_SCROLL;
            r0.scroll_rows   = (needed < {1'b0, total}) ? needed[RW-1:0] : total;
            r1.pos_x         = col0;
            r1.pos_y         = row_fin;
            r1.glyph         = item.char_code;
            r1.draw_color    = item.color;
            r1.last          = 1'b1;
            push.num         = 2'd2;
          end else begin
            cursor_y_next = row0;
            r0.pos_x      = col0;
            r0.pos_y      = row0;
            r0.glyph      = item.char_code;
            r0.draw_color = item.color;
            r0.last       = 1'b1;
            push.num      = 2'd1;
          end
        end
      endcase
    end

    push.first  = r0;
    push.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      cursor_y    <= '0;
      rows_in_use <= '0;
    end else if (commit) begin
      cursor_x    <= cursor_x_next;
      cursor_y    <= cursor_y_next;
      rows_in_use <= rows_in_use_next;
    end
  end

endmodule

>>> sv/tcce_out_queue.sv
// Two-slot result register: the head drives the output, the second slot waits behind it.
`timescale 1ns / 1ps

module tcce_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tcce_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output tcce_pkg::result_t out_result
);

  logic [1:0]        count;
  tcce_pkg::result_t head;
  tcce_pkg::result_t tail;
  logic              pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 2'd0);
  assign out_result = head;

  // New results only enter when the queue will be empty at this edge.
  assign room = (count == 2'd0) || ((count == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= push.num;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= push.first;
      tail <= push.second;
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

>>> sv/tcce_checker.sv
// Port-level assertions for the text console cursor engine, bound to the top level.
`timescale 1ns / 1ps

module tcce_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_clear_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tcce_pkg::KIND_CLEAR) |-> m_tlast)
    else $error("clear must be the only result of its item");

  a_only_scroll_leads: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tuser == tcce_pkg::KIND_SCROLL))
    else $error("only a scroll may precede another result of the same item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> tb/tb_top.sv
// Self-checking testbench for the text console cursor engine top level.
`timescale 1ns / 1ps

// The bench drives characters and clear commands into the slave stream. A scoreboard
// predicts the draw, scroll and clear commands that each accepted transfer must cause.
// A clocked driver takes items from a queue that the main initial block fills, one
// phase at a time. A clocked monitor checks every master-side transfer field by field
// against the oldest expected command.
//
// Each phase starts from an idle engine. The bench writes all three registers first,
// so the run covers the narrowest and lowest screen, the largest one, the reset
// values and random sizes. The phases rotate through four flow-control mixes. In the
// first, neither side idles. In the second, the sender idles in about half of the
// cycles. In the third, the receiver stalls about as often. In the last, both sides
// pause now and then. Halfway through each phase the sender holds its next item
// until every expected command has arrived.
module tb_top;
  import tcce_pkg::*;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TAB_STEP      = 2'd2;

  // Input commands and the control characters the engine interprets.
  localparam logic       CMD_PUT   = 1'b0;
  localparam logic       CMD_CLEAR = 1'b1;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int PHASES     = 8;
  localparam int PHASE_OPS  = 225;
  localparam int RUN_LIMIT  = 500000;
  localparam int TAIL_WAIT  = 20;
  localparam int QUIET_WAIT = 8;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic        cmd;
    logic [7:0]  ch;
    logic [23:0] color;
    bit          drain_first;  // Hold this item until no command is outstanding.
  } console_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // char_code [7:0], color [31:8]
  logic        s_tuser = 1'b0;  // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;  // pos_x, pos_y, glyph, draw_color, scroll_rows, zero pad
  logic [1:0]  m_tuser;  // kind
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  text_console_cursor_engine_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Pending stimulus, and the console commands that accepted items have yet to cause.
  console_op_t op_queue[$];
  result_t     expected_cmds[$];
  console_op_t next_op;
  int          ops_queued = 0;
  int          ops_accepted = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Scoreboard copy of the engine state and configuration.
  int unsigned cfg_width = 1024;
  int unsigned cfg_height = 768;
  int unsigned cfg_tab = 32;
  int unsigned cur_x = 0;
  int unsigned cur_y = 0;
  int unsigned used_rows = 0;

  function automatic int unsigned sat_xy(int unsigned v);
    return (v > XY_MAX) ? XY_MAX : v;
  endfunction

  // A scroll never asks for more rows than the screen holds or the field carries.
  function automatic int unsigned scroll_limit(int unsigned needed, int unsigned total);
    int unsigned n;
    n = (needed < total) ? needed : total;
    return (n > ROWS_MAX) ? ROWS_MAX : n;
  endfunction

  function automatic result_t make_cmd(kind_t k, int unsigned x, int unsigned y,
                                       int unsigned g, int unsigned c, int unsigned rows);
    result_t r;
    r.kind        = k;
    r.pos_x       = XY_W'(x);
    r.pos_y       = XY_W'(y);
    r.glyph       = CHAR_W'(g);
    r.draw_color  = COLOR_W'(c);
    r.scroll_rows = ROWS_W'(rows);
    r.last        = 1'b0;
    return r;
  endfunction

  // Advances the cursor model by one accepted item and queues the commands it causes.
  task automatic console_predict(input logic cmd, input logic [7:0] ch,
                                 input logic [23:0] color);
    int unsigned total;
    int unsigned excess;
    int unsigned up;
    int unsigned over;
    int unsigned needed;
    result_t     outs[2];
    int          n;
    total = cfg_height / GLYPH_HEIGHT;
    n = 0;
    if (cmd == CMD_CLEAR) begin
      // A clear ignores the character and the color and sends the cursor home.
      cur_x = 0;
      cur_y = 0;
      used_rows = 0;
      outs[n] = make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0);
      n = n + 1;
    end else if (ch == CH_NL) begin
      cur_x = 0;
      cur_y = sat_xy(cur_y + GLYPH_HEIGHT);
      if (used_rows < ROWS_MAX) used_rows = used_rows + 1;
      if (used_rows > total) begin
        // More rows are in use than fit: scroll the excess and follow it with the cursor.
        excess = used_rows - total;
        up = excess * GLYPH_HEIGHT;
        used_rows = total;
        cur_y = (cur_y > up) ? cur_y - up : 0;
        outs[n] = make_cmd(KIND_SCROLL, 0, 0, 0, 0, scroll_limit(excess, total));
        n = n + 1;
      end
    end else if (ch == CH_TAB) begin
      cur_x = sat_xy(cur_x + cfg_tab);
    end else if (ch == CH_BS) begin
      if (cur_x > 0) begin
        cur_x = (cur_x > GLYPH_WIDTH) ? cur_x - GLYPH_WIDTH : 0;
        outs[n] = make_cmd(KIND_DRAW, cur_x, cur_y, CH_SPACE, color, 0);
        n = n + 1;
      end else if (cur_y >= GLYPH_HEIGHT) begin
        // At column 0 below the top row the cursor steps to the end of the row above.
        cur_x = (cfg_width > GLYPH_WIDTH) ? cfg_width - GLYPH_WIDTH : 0;
        cur_y = cur_y - GLYPH_HEIGHT;
        outs[n] = make_cmd(KIND_DRAW, cur_x, cur_y, CH_SPACE, color, 0);
        n = n + 1;
      end
    end else begin
      if (cur_x >= cfg_width) begin
        cur_x = 0;
        cur_y = sat_xy(cur_y + GLYPH_HEIGHT);
      end
      if (total == 0) begin
        cur_y = 0;
      end else if (cur_y + GLYPH_HEIGHT > cfg_height) begin
        // The cell would hang below the screen: scroll up just the rows it needs.
        over = cur_y + GLYPH_HEIGHT - cfg_height;
        needed = (over + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
        up = needed * GLYPH_HEIGHT;
        cur_y = (cur_y > up) ? cur_y - up : 0;
        used_rows = (used_rows > needed) ? used_rows - needed : 0;
        outs[n] = make_cmd(KIND_SCROLL, 0, 0, 0, 0, scroll_limit(needed, total));
        n = n + 1;
      end
      outs[n] = make_cmd(KIND_DRAW, cur_x, cur_y, ch, color, 0);
      n = n + 1;
      cur_x = sat_xy(cur_x + GLYPH_WIDTH);
    end
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_cmds.push_back(outs[i]);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Checks one master-side transfer against the oldest expected command.
  task automatic check_transfer();
    result_t want;
    if (expected_cmds.size() == 0) begin
      flag_mismatch($sformatf("transfer of kind %0d with nothing expected", m_tuser));
    end else begin
      want = expected_cmds.pop_front();
      compare_field("kind", m_tuser, want.kind);
      compare_field("pos_x", m_tdata[12:0], want.pos_x);
      compare_field("pos_y", m_tdata[25:13], want.pos_y);
      compare_field("glyph", m_tdata[33:26], want.glyph);
      compare_field("draw_color", m_tdata[57:34], want.draw_color);
      compare_field("scroll_rows", m_tdata[66:58], want.scroll_rows);
      compare_field("pad", m_tdata[71:67], 0);
      compare_field("last", m_tlast, want.last);
    end
  endtask

  // Driver: a new item goes out only when the slave side is free or the current one
  // is taken at this edge, so tvalid and its data hold steady while the slave side stalls.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        console_predict(s_tuser, s_tdata[7:0], s_tdata[31:8]);
        ops_accepted++;
      end
      if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          (!op_queue[0].drain_first || expected_cmds.size() == 0)) begin
        next_op = op_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {next_op.color, next_op.ch};
        s_tuser <= next_op.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each master-side transfer and draws a new stall decision every cycle.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_transfer();
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("text_console_cursor_engine_core: mismatch");
      $finish;
    end
  end

  task automatic queue_op(input logic cmd, input logic [7:0] ch, input logic [23:0] color,
                          input bit drain);
    console_op_t op;
    op.cmd = cmd;
    op.ch = ch;
    op.color = color;
    op.drain_first = drain;
    op_queue.push_back(op);
    ops_queued++;
  endtask

  // Random traffic that keeps the cursor moving: mostly printable cells, with frequent
  // newlines, tabs and backspaces so that wraps, scrolls and row steps come often.
  task automatic queue_random_op(input bit drain);
    int unsigned pick;
    logic [7:0]  ch;
    pick = $urandom_range(99);
    if (pick < 20) ch = CH_NL;
    else if (pick < 30) ch = CH_TAB;
    else if (pick < 42) ch = CH_BS;
    else ch = 8'($urandom_range(255));
    queue_op(($urandom_range(99) < 3) ? CMD_CLEAR : CMD_PUT, ch,
             24'($urandom_range(24'hFFFFFF)), drain);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 13'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH: cfg_width = value;
      REG_SCREEN_HEIGHT: cfg_height = value;
      REG_TAB_STEP: cfg_tab = value;
      default: ;
    endcase
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h, input int unsigned t);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_TAB_STEP, t);
  endtask

  // Waits until every queued item was taken and every expected command arrived, then
  // gives an item without results time to retire before the registers change.
  task automatic wait_quiet();
    while (ops_accepted != ops_queued || expected_cmds.size() != 0) @(posedge clk);
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  task automatic set_flow(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values of the registers: draw, tab, backspace and newline on a 1024x768 screen.
    set_flow(0);
    queue_op(CMD_PUT, "A", 24'h00FF00, 1'b0);
    queue_op(CMD_PUT, CH_TAB, 24'h000000, 1'b0);
    queue_op(CMD_PUT, CH_BS, 24'hFFFFFF, 1'b0);
    queue_op(CMD_PUT, CH_NL, 24'h000000, 1'b0);
    wait_quiet();

    // A screen three cells wide and two rows high, so that wraps and scrolls come quickly.
    set_screen(24, 32, 8);
    queue_op(CMD_CLEAR, 8'h00, 24'h000000, 1'b0);
    queue_op(CMD_PUT, CH_BS, 24'h123456, 1'b0);    // top-left corner: nothing happens
    queue_op(CMD_PUT, 8'h00, 24'h000000, 1'b0);
    queue_op(CMD_PUT, 8'hFF, 24'hFFFFFF, 1'b0);
    queue_op(CMD_PUT, "a", 24'h123456, 1'b0);
    queue_op(CMD_PUT, "b", 24'hABCDEF, 1'b0);      // wraps at the right edge
    queue_op(CMD_PUT, "c", 24'h800001, 1'b0);
    queue_op(CMD_PUT, "d", 24'h7FFFFE, 1'b0);
    queue_op(CMD_PUT, "e", 24'h010203, 1'b0);      // wraps below the screen: scroll, draw
    queue_op(CMD_PUT, CH_BS, 24'h00FFFF, 1'b0);
    queue_op(CMD_PUT, CH_BS, 24'hFF00FF, 1'b0);    // column 0: back to the row above
    queue_op(CMD_PUT, CH_NL, 24'h000000, 1'b0);
    queue_op(CMD_PUT, CH_NL, 24'h000000, 1'b0);
    queue_op(CMD_PUT, CH_NL, 24'h000000, 1'b0);    // one row too many: scroll by one
    queue_op(CMD_PUT, CH_TAB, 24'h000000, 1'b0);
    queue_op(CMD_PUT, CH_TAB, 24'h000000, 1'b0);
    queue_op(CMD_PUT, CH_TAB, 24'h000000, 1'b0);
    queue_op(CMD_PUT, CH_TAB, 24'h000000, 1'b0);
    queue_op(CMD_PUT, "f", 24'h555555, 1'b0);      // past the edge and low: scroll of two
    queue_op(CMD_CLEAR, 8'hFF, 24'hFFFFFF, 1'b0);  // clear ignores the character
    queue_op(CMD_CLEAR, CH_BS, 24'hAAAAAA, 1'b0);
    queue_op(CMD_PUT, "g", 24'hFFFFFF, 1'b1);
    wait_quiet();

    // Random phases. Phase 1 leaves many rows in use on a tall screen and phase 2 then
    // shrinks the screen to one row, so that larger scrolls are asked for and cut to one row.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_screen(8, 16, 0);
        1: set_screen(4096, 4096, 256);
        2: set_screen($urandom_range(8, 200), 16, $urandom_range(0, 256));
        3: set_screen(1024, 768, 32);
        4: set_screen($urandom_range(8, 200), $urandom_range(16, 300), $urandom_range(0, 256));
        5: set_screen($urandom_range(8, 4096), $urandom_range(16, 4096),
                      $urandom_range(0, 256));
        6: set_screen(4096, 16, 256);
        default: set_screen(8, 4096, 1);
      endcase
      set_flow(phase % 4);
      for (int k = 0; k < PHASE_OPS; k++) queue_random_op(k == PHASE_OPS / 2);
      wait_quiet();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("text_console_cursor_engine_core: match");
    end else begin
      $display("text_console_cursor_engine_core: mismatch");
    end
    $finish;
  end

endmodule
